>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/i2cm_pkg.sv
// Types and constants of the I2C master byte engine.
package i2cm_pkg;

    // Bus phases, one-hot
    typedef enum logic [10:0] {
        PH_IDLE  = 11'b000_0000_0001,
        PH_ST1   = 11'b000_0000_0010,
        PH_ST2   = 11'b000_0000_0100,
        PH_ST3   = 11'b000_0000_1000,
        PH_ST4   = 11'b000_0001_0000,
        PH_BSET  = 11'b000_0010_0000,
        PH_BHIGH = 11'b000_0100_0000,
        PH_BLOW  = 11'b000_1000_0000,
        PH_SP1   = 11'b001_0000_0000,
        PH_SP2   = 11'b010_0000_0000,
        PH_SP3   = 11'b100_0000_0000
    } phase_t;

    // Command codes
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_TX   = 2'd1;
    localparam logic [1:0] ACT_RX   = 2'd2;

    // Operation flag bit positions
    localparam int FL_STOP = 0;
    localparam int FL_RX   = 1;
    localparam int FL_ACK  = 2;
    localparam int FL_SEEN = 3;

    // Line drive bit positions
    localparam int DRV_SCL = 0;
    localparam int DRV_SDA = 1;

    localparam logic [3:0]  DATA_BITS         = 4'd8;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

    // Delay length; zero acts as one
    function automatic logic [15:0] ticks_of(input logic [15:0] pt);
        return (pt == 16'd0) ? 16'd1 : pt;
    endfunction

endpackage

>>> rtl/core/i2cm_if.sv
// Command and result channel interfaces of the I2C master byte engine.
interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_data;
    logic       send_start;
    logic       send_stop;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;

    modport source (
        output valid, action, tx_data, send_start, send_stop, ack_to_send, scl_in, sda_in,
        input  ready
    );
    modport sink (
        input  valid, action, tx_data, send_start, send_stop, ack_to_send, scl_in, sda_in,
        output ready
    );
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       nack_seen;
    logic       cmd_rejected;

    modport source (
        output valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_data,
               nack_seen, cmd_rejected,
        input  ready
    );
    modport sink (
        input  valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_data,
               nack_seen, cmd_rejected,
        output ready
    );
endinterface

>>> rtl/core/i2c_master_byte_engine.sv
// Top level of the open-drain I2C master byte engine.
//
//   channel   | dir | payload                                          | handshake
//   ----------+-----+--------------------------------------------------+------------
//   cmd_bus   | in  | action tx_data send_start send_stop ack_to_send  | valid/ready
//             |     | scl_in sda_in                                    |
//   res_bus   | out | scl_drive_low sda_drive_low busy_res done_res    | valid/ready
//             |     | rx_data nack_seen cmd_rejected                   |
//   cfg       | in  | cfg_wdata (phase_ticks)                          | cfg_we
//
// One tick per cycle: each transfer on cmd_bus updates the sequencer state and
// loads one result into the output register, shown on res_bus the next cycle.
// cmd_bus is ready whenever the output register is empty or being drained.
// A stalled res_bus holds its result and stalls cmd_bus in the same cycle.
// Reset releases both lines, goes idle and sets phase_ticks to 100.
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    i2cm_cmd_if.sink      cmd_bus,
    i2cm_res_if.source    res_bus,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_count_reg, delay_count_next;
    logic [3:0]  op_flags_reg, op_flags_next;
    logic [1:0]  line_drive_reg, line_drive_next;
    logic [15:0] phase_ticks_reg;

    // Output register
    logic        res_valid_reg;
    logic        scl_low_reg, sda_low_reg, busy_reg, done_reg, nack_reg, rej_reg;
    logic [7:0]  rx_data_reg;

    logic        take;
    logic        is_cmd;
    logic        enter;
    logic        finish;
    logic        done_now;
    logic        rej_now;
    logic        bit_val;
    logic [15:0] ticks;
    logic [15:0] delay_dec;
    phase_t      target;

    assign take    = cmd_bus.valid && cmd_bus.ready;
    assign is_cmd  = (cmd_bus.action == ACT_TX) || (cmd_bus.action == ACT_RX);
    assign ticks   = ticks_of(phase_ticks_reg);
    assign delay_dec = (delay_count_reg != 16'd0) ? delay_count_reg - 16'd1 : 16'd0;

    // Compute the next sequencer state for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        op_flags_next    = op_flags_reg;
        line_drive_next  = line_drive_reg;
        enter            = 1'b0;
        finish           = 1'b0;
        rej_now          = 1'b0;
        target           = PH_IDLE;
        bit_val          = 1'b1;

        if (phase_reg == PH_IDLE)
        begin
            // Start a command
            if (is_cmd)
            begin
                bit_count_next = 4'd0;
                enter          = 1'b1;
                if (cmd_bus.action == ACT_TX)
                begin
                    shift_next    = cmd_bus.tx_data;
                    op_flags_next = 4'd0;
                    op_flags_next[FL_STOP] = cmd_bus.send_stop;
                    target        = cmd_bus.send_start ? PH_ST1 : PH_BSET;
                end
                else
                begin
                    shift_next    = 8'd0;
                    op_flags_next = 4'd0;
                    op_flags_next[FL_RX]   = 1'b1;
                    op_flags_next[FL_STOP] = cmd_bus.send_stop;
                    op_flags_next[FL_ACK]  = cmd_bus.ack_to_send;
                    target        = PH_BSET;
                end
            end
        end
        else
        begin
            rej_now = is_cmd;
            if (((phase_reg == PH_BHIGH) || (phase_reg == PH_SP2)) && !op_flags_reg[FL_SEEN])
            begin
                // Wait for SCL high, then sample SDA
                if (cmd_bus.scl_in)
                begin
                    op_flags_next[FL_SEEN] = 1'b1;
                    delay_count_next       = ticks;
                    if (phase_reg == PH_BHIGH)
                    begin
                        if (bit_count_reg < DATA_BITS)
                        begin
                            if (op_flags_reg[FL_RX])
                                shift_next = {shift_reg[6:0], cmd_bus.sda_in};
                        end
                        else if (!op_flags_reg[FL_RX])
                        begin
                            op_flags_next[FL_ACK] = cmd_bus.sda_in;
                        end
                    end
                end
            end
            else
            begin
                // Count down the delay, advance when it runs out
                delay_count_next = delay_dec;
                if (delay_dec == 16'd0)
                begin
                    unique case (phase_reg)
                        PH_ST1:   begin target = PH_ST2;   enter = 1'b1; end
                        PH_ST2:   begin target = PH_ST3;   enter = 1'b1; end
                        PH_ST3:   begin target = PH_ST4;   enter = 1'b1; end
                        PH_ST4:   begin target = PH_BSET;  enter = 1'b1; end
                        PH_BSET:  begin target = PH_BHIGH; enter = 1'b1; end
                        PH_BHIGH: begin target = PH_BLOW;  enter = 1'b1; end
                        PH_BLOW:
                        begin
                            if (bit_count_reg < DATA_BITS)
                            begin
                                if (!op_flags_reg[FL_RX])
                                    shift_next = {shift_reg[6:0], 1'b0};
                                bit_count_next = bit_count_reg + 4'd1;
                                target         = PH_BSET;
                                enter          = 1'b1;
                            end
                            else if (op_flags_reg[FL_STOP])
                            begin
                                target = PH_SP1;
                                enter  = 1'b1;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        PH_SP1:   begin target = PH_SP2;   enter = 1'b1; end
                        PH_SP2:   begin target = PH_SP3;   enter = 1'b1; end
                        PH_SP3:   finish = 1'b1;
                        default:  finish = 1'b0;
                    endcase
                end
            end
        end

        // Drop back to idle on completion
        if (finish)
        begin
            phase_next       = PH_IDLE;
            delay_count_next = 16'd0;
        end

        // Enter the next phase and set its lines
        if (enter)
        begin
            phase_next       = target;
            delay_count_next = ticks;
            unique case (target)
                PH_ST1:   line_drive_next[DRV_SCL] = 1'b0;
                PH_ST2:   line_drive_next = 2'b00;
                PH_ST3:   line_drive_next[DRV_SDA] = 1'b1;
                PH_ST4:   line_drive_next[DRV_SCL] = 1'b1;
                PH_BSET:
                begin
                    if (bit_count_next < DATA_BITS)
                        bit_val = op_flags_next[FL_RX] ? 1'b1 : shift_next[7];
                    else
                        bit_val = op_flags_next[FL_RX] ? op_flags_next[FL_ACK] : 1'b1;
                    line_drive_next[DRV_SDA] = ~bit_val;
                end
                PH_BHIGH, PH_SP2:
                begin
                    line_drive_next[DRV_SCL] = 1'b0;
                    op_flags_next[FL_SEEN]   = 1'b0;
                    delay_count_next         = 16'd0;
                end
                PH_BLOW:  line_drive_next[DRV_SCL] = 1'b1;
                PH_SP1:   line_drive_next[DRV_SDA] = 1'b1;
                PH_SP3:   line_drive_next[DRV_SDA] = 1'b0;
                default:
                begin
                    phase_next       = PH_IDLE;
                    delay_count_next = 16'd0;
                end
            endcase
        end
    end

    assign done_now = finish;

    // Advance the sequencer on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            delay_count_reg <= 16'd0;
            op_flags_reg    <= 4'd0;
            line_drive_reg  <= 2'b00;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            op_flags_reg    <= op_flags_next;
            line_drive_reg  <= line_drive_next;
        end
    end

    // Hold the delay setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= PHASE_TICKS_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (take)
            res_valid_reg <= 1'b1;
        else if (res_bus.ready)
            res_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            scl_low_reg <= line_drive_next[DRV_SCL];
            sda_low_reg <= line_drive_next[DRV_SDA];
            busy_reg    <= (phase_next != PH_IDLE);
            done_reg    <= done_now;
            rx_data_reg <= (done_now && op_flags_next[FL_RX]) ? shift_next : 8'd0;
            nack_reg    <= done_now && !op_flags_next[FL_RX] && op_flags_next[FL_ACK];
            rej_reg     <= rej_now;
        end
    end

    assign cmd_bus.ready         = !res_valid_reg || res_bus.ready;
    assign res_bus.valid         = res_valid_reg;
    assign res_bus.scl_drive_low = scl_low_reg;
    assign res_bus.sda_drive_low = sda_low_reg;
    assign res_bus.busy_res      = busy_reg;
    assign res_bus.done_res      = done_reg;
    assign res_bus.rx_data       = rx_data_reg;
    assign res_bus.nack_seen     = nack_reg;
    assign res_bus.cmd_rejected  = rej_reg;

endmodule

>>> rtl/core/i2cm_checker.sv
// Port-level checks of the I2C master byte engine, bound to the top level.
`include "assert_macros.svh"

module i2cm_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       cmd_ready,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic [7:0] rx_data,
    input  logic       nack_seen
);

    // Every command transfer yields a result next cycle
    `ASSERT_NEXT(a_cmd_gives_res, clk, rst_n, cmd_valid && cmd_ready, res_valid, "no result")

    // A completed command leaves the engine idle
    `ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, res_valid && done_res, !busy_res, "busy on done")

    // Received byte and acknowledge only show on completion
    `ASSERT_IMPLIES(a_rx_only_done, clk, rst_n, res_valid && |rx_data, done_res, "stray rx_data")
    `ASSERT_IMPLIES(a_nack_done, clk, rst_n, res_valid && nack_seen, done_res, "stray nack")

    // A stalled result stays offered
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_bus.valid),
    .cmd_ready (cmd_bus.ready),
    .res_valid (res_bus.valid),
    .res_ready (res_bus.ready),
    .busy_res  (res_bus.busy_res),
    .done_res  (res_bus.done_res),
    .rx_data   (res_bus.rx_data),
    .nack_seen (res_bus.nack_seen)
);

>>> tb/tb_top.sv
// Self-checking testbench for the I2C master byte engine: tick stream in, line results out.
module tb_top;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code 3 is unused and behaves as a plain tick
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int GAP_PCT = 23;
    localparam int STALL_CYCLES = 80;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_data;
        logic       send_start;
        logic       send_stop;
        logic       ack_to_send;
        logic       scl_in;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_data;
        logic       nack;
        logic       rejected;
    } tick_result_t;

    typedef struct packed {
        phase_t      ph;
        logic [3:0]  bits;
        logic [7:0]  sh;
        logic [15:0] dly;
        logic [3:0]  fl;
        logic [1:0]  drv;
        logic [15:0] pt;
    } engine_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2cm_cmd_if cmd_bus ();
    i2cm_res_if res_bus ();

    i2c_master_byte_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_bus   (cmd_bus),
        .res_bus   (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    engine_t      line_model;    // tracks accepted ticks, feeds the checker
    engine_t      plan_model;    // runs ahead while the stimulus is planned
    tick_item_t   tick_q[$];
    tick_result_t expected_q[$];
    tick_item_t   offer;
    tick_result_t predicted;
    tick_result_t oldest;
    logic         cmd_took;
    logic         no_gaps;
    logic         stall_req;
    int           stall_left;
    int           fail_count;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------
    // Engine predictor
    // ---------------------------------------------------------------

    function automatic logic [15:0] delay_len(input logic [15:0] pt);
        return (pt == 16'd0) ? 16'd1 : pt;
    endfunction

    function automatic engine_t reset_engine();
        engine_t s;
        s = '0;
        s.ph = PH_IDLE;
        s.pt = PHASE_TICKS_RESET;
        return s;
    endfunction

    // Enter a phase: load its delay and set the lines it calls for
    function automatic void move_to(inout engine_t s, input phase_t p);
        logic level;
        s.ph = p;
        s.dly = delay_len(s.pt);
        case (p)
            PH_ST1: s.drv[DRV_SCL] = 1'b0;
            PH_ST2: s.drv = 2'b00;
            PH_ST3: s.drv[DRV_SDA] = 1'b1;
            PH_ST4: s.drv[DRV_SCL] = 1'b1;
            PH_BSET:
            begin
                // data bit, or the acknowledge slot after eight bits
                if (s.bits < DATA_BITS)
                    level = s.fl[FL_RX] ? 1'b1 : s.sh[7];
                else
                    level = s.fl[FL_RX] ? s.fl[FL_ACK] : 1'b1;
                s.drv[DRV_SDA] = !level;
            end
            PH_BHIGH, PH_SP2:
            begin
                s.drv[DRV_SCL] = 1'b0;
                s.fl[FL_SEEN] = 1'b0;
                s.dly = '0;
            end
            PH_BLOW: s.drv[DRV_SCL] = 1'b1;
            PH_SP1: s.drv[DRV_SDA] = 1'b1;
            PH_SP3: s.drv[DRV_SDA] = 1'b0;
            default:
            begin
                s.ph = PH_IDLE;
                s.dly = '0;
            end
        endcase
    endfunction

    // Step to the next phase once a delay runs out; returns 1 on completion
    function automatic logic finish_delay(inout engine_t s);
        logic fin;
        fin = 1'b0;
        case (s.ph)
            PH_ST1: move_to(s, PH_ST2);
            PH_ST2: move_to(s, PH_ST3);
            PH_ST3: move_to(s, PH_ST4);
            PH_ST4: move_to(s, PH_BSET);
            PH_BSET: move_to(s, PH_BHIGH);
            PH_BHIGH: move_to(s, PH_BLOW);
            PH_BLOW:
            begin
                if (s.bits < DATA_BITS)
                begin
                    if (!s.fl[FL_RX])
                        s.sh = s.sh << 1;
                    s.bits = s.bits + 4'd1;
                    move_to(s, PH_BSET);
                end
                else if (s.fl[FL_STOP])
                    move_to(s, PH_SP1);
                else
                    fin = 1'b1;
            end
            PH_SP1: move_to(s, PH_SP2);
            PH_SP2: move_to(s, PH_SP3);
            PH_SP3: fin = 1'b1;
            default:
            begin
                s.ph = PH_IDLE;
                s.dly = '0;
            end
        endcase
        if (fin)
        begin
            s.ph = PH_IDLE;
            s.dly = '0;
        end
        return fin;
    endfunction

    // Advance the engine by one tick and return what the block shows for it
    function automatic tick_result_t next_tick(inout engine_t s, input tick_item_t it);
        tick_result_t r;
        logic         is_cmd;
        r = '0;
        is_cmd = (it.action == ACT_TX) || (it.action == ACT_RX);
        if (s.ph == PH_IDLE)
        begin
            if (is_cmd)
            begin
                s.bits = '0;
                s.fl = '0;
                s.fl[FL_STOP] = it.send_stop;
                if (it.action == ACT_TX)
                begin
                    s.sh = it.tx_data;
                    move_to(s, it.send_start ? PH_ST1 : PH_BSET);
                end
                else
                begin
                    // a start request is ignored on receive
                    s.sh = '0;
                    s.fl[FL_RX] = 1'b1;
                    s.fl[FL_ACK] = it.ack_to_send;
                    move_to(s, PH_BSET);
                end
            end
        end
        else
        begin
            r.rejected = is_cmd;
            if ((s.ph == PH_BHIGH || s.ph == PH_SP2) && !s.fl[FL_SEEN])
            begin
                // wait out clock stretching, sample SDA on SCL high
                if (it.scl_in)
                begin
                    s.fl[FL_SEEN] = 1'b1;
                    s.dly = delay_len(s.pt);
                    if (s.ph == PH_BHIGH)
                    begin
                        if (s.bits < DATA_BITS)
                        begin
                            if (s.fl[FL_RX])
                                s.sh = {s.sh[6:0], it.sda_in};
                        end
                        else if (!s.fl[FL_RX])
                            s.fl[FL_ACK] = it.sda_in;
                    end
                end
            end
            else
            begin
                if (s.dly != 16'd0)
                    s.dly = s.dly - 16'd1;
                if (s.dly == 16'd0)
                    r.done = finish_delay(s);
            end
        end
        r.scl_low = s.drv[DRV_SCL];
        r.sda_low = s.drv[DRV_SDA];
        r.busy = (s.ph != PH_IDLE);
        r.rx_data = (r.done && s.fl[FL_RX]) ? s.sh : 8'd0;
        r.nack = r.done && !s.fl[FL_RX] && s.fl[FL_ACK];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus planning
    // ---------------------------------------------------------------

    function automatic tick_item_t rand_tick();
        tick_item_t it;
        it.action = ACT_TICK;
        it.tx_data = 8'($urandom);
        it.send_start = 1'($urandom);
        it.send_stop = 1'($urandom);
        it.ack_to_send = 1'($urandom);
        it.scl_in = ($urandom_range(99) < 80);
        it.sda_in = 1'($urandom);
        return it;
    endfunction

    function automatic tick_item_t rand_cmd();
        tick_item_t it;
        it = rand_tick();
        it.action = $urandom_range(1) ? ACT_TX : ACT_RX;
        return it;
    endfunction

    function automatic tick_item_t make_cmd(input logic [1:0] act, input logic [7:0] data,
                                            input logic start, input logic stop,
                                            input logic ack);
        tick_item_t it;
        it = rand_tick();
        it.action = act;
        it.tx_data = data;
        it.send_start = start;
        it.send_stop = stop;
        it.ack_to_send = ack;
        return it;
    endfunction

    task automatic add_tick(input tick_item_t it);
        void'(next_tick(plan_model, it));
        tick_q.push_back(it);
    endtask

    // One tick while a command runs; sometimes a command that must be refused
    task automatic busy_tick(input int noise_pct);
        tick_item_t   it;
        engine_t      probe;
        tick_result_t r;
        it = rand_tick();
        probe = plan_model;
        r = next_tick(probe, it);
        if (r.done && $urandom_range(1))
            it.action = $urandom_range(1) ? ACT_TX : ACT_RX;
        else if ($urandom_range(99) < noise_pct)
            it.action = 2'($urandom_range(1, 3));
        add_tick(it);
    endtask

    task automatic run_to_idle(input int noise_pct);
        while (plan_model.ph != PH_IDLE)
            busy_tick(noise_pct);
    endtask

    task automatic issue(input tick_item_t it);
        run_to_idle(8);
        add_tick(it);
    endtask

    task automatic directed_cmds();
        tick_item_t it;
        it = rand_tick();
        it.action = ACT_UNUSED;
        add_tick(it);
        add_tick(it);
        issue(make_cmd(ACT_TX, 8'hFF, 1'b1, 1'b1, 1'b0));
        issue(make_cmd(ACT_RX, 8'h5A, 1'b1, 1'b1, 1'b1));
        issue(make_cmd(ACT_TX, 8'h81, 1'b0, 1'b0, 1'b0));
        run_to_idle(8);
    endtask

    // Mostly complete commands with random content, plus idle and noise ticks
    task automatic random_ticks(input int n);
        tick_item_t it;
        repeat (n)
        begin
            if (plan_model.ph == PH_IDLE)
            begin
                if ($urandom_range(99) < 70)
                    it = rand_cmd();
                else
                begin
                    it = rand_tick();
                    if ($urandom_range(3) == 0)
                        it.action = ACT_UNUSED;
                end
                add_tick(it);
            end
            else
                busy_tick(4);
        end
        run_to_idle(4);
    endtask

    task automatic drain();
        while (tick_q.size() != 0 || cmd_bus.valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_ticks(input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        plan_model.pt = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns %s: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // Command driver
    // ---------------------------------------------------------------

    // Note each transfer on the command side and predict its result
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            line_model.pt = cfg_wdata;
        cmd_took = rst_n && cmd_bus.valid && cmd_bus.ready;
        if (cmd_took)
        begin
            predicted = next_tick(line_model, offer);
            expected_q.push_back(predicted);
        end
    end

    // Offer the next tick after a transfer, with random gaps unless no_gaps is set
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else if (!cmd_bus.valid || cmd_took)
        begin
            if (tick_q.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT))
            begin
                offer = tick_q.pop_front();
                cmd_bus.action <= offer.action;
                cmd_bus.tx_data <= offer.tx_data;
                cmd_bus.send_start <= offer.send_start;
                cmd_bus.send_stop <= offer.send_stop;
                cmd_bus.ack_to_send <= offer.ack_to_send;
                cmd_bus.scl_in <= offer.scl_in;
                cmd_bus.sda_in <= offer.sda_in;
                cmd_bus.valid <= 1'b1;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result receiver and monitor
    // ---------------------------------------------------------------

    // Drop ready at random unless no_gaps is set; hold it low for a long stretch on request
    always @(negedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (stall_left > 0)
                stall_left--;
            else if (stall_req)
            begin
                stall_left = STALL_CYCLES;
                stall_req = 1'b0;
            end
            res_bus.ready <= (stall_left == 0) && (no_gaps || $urandom_range(99) >= GAP_PCT);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_q.size() == 0)
            begin
                fail_count++;
                $display("%0t ns result: expected none, actual scl %0b sda %0b busy %0b",
                         $time, res_bus.scl_drive_low, res_bus.sda_drive_low,
                         res_bus.busy_res);
            end
            else
            begin
                oldest = expected_q.pop_front();
                check_field("scl_drive_low", 8'(oldest.scl_low), 8'(res_bus.scl_drive_low));
                check_field("sda_drive_low", 8'(oldest.sda_low), 8'(res_bus.sda_drive_low));
                check_field("busy_res", 8'(oldest.busy), 8'(res_bus.busy_res));
                check_field("done_res", 8'(oldest.done), 8'(res_bus.done_res));
                check_field("rx_data", oldest.rx_data, res_bus.rx_data);
                check_field("nack_seen", 8'(oldest.nack), 8'(res_bus.nack_seen));
                check_field("cmd_rejected", 8'(oldest.rejected), 8'(res_bus.cmd_rejected));
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.action = ACT_TICK;
        cmd_bus.tx_data = '0;
        cmd_bus.send_start = 1'b0;
        cmd_bus.send_stop = 1'b0;
        cmd_bus.ack_to_send = 1'b0;
        cmd_bus.scl_in = 1'b1;
        cmd_bus.sda_in = 1'b1;
        res_bus.ready = 1'b0;
        cmd_took = 1'b0;
        no_gaps = 1'b0;
        stall_req = 1'b0;
        stall_left = 0;
        fail_count = 0;
        line_model = reset_engine();
        plan_model = reset_engine();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // start a transfer at the reset delay setting, finish it at the shortest
        issue(make_cmd(ACT_TX, 8'h3C, 1'b0, 1'b1, 1'b0));
        repeat (10) busy_tick(10);
        drain();
        set_ticks(16'd1);
        run_to_idle(4);
        drain();

        // directed commands at the shortest delay
        directed_cmds();
        drain();

        // zero delay acts as one
        set_ticks(16'd0);
        random_ticks(30);
        drain();

        // stretch with no idling on either side
        set_ticks(16'd2);
        no_gaps = 1'b1;
        random_ticks(40);
        drain();
        no_gaps = 1'b0;

        // long receiver stall while ticks keep coming
        set_ticks(16'd1);
        stall_req = 1'b1;
        random_ticks(30);
        drain();

        // longest delay: start a transfer and refuse commands while it runs
        set_ticks(16'hFFFF);
        issue(make_cmd(ACT_TX, 8'hC3, 1'b1, 1'b1, 1'b0));
        repeat (20) busy_tick(10);
        drain();

        repeat (5) @(negedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
